// File: src/tgw_pkg.sv
// Shared constants, register map and types of the timer group with watchdog.
`default_nettype none
package tgw_pkg;

  // Counter width of both timers
  localparam int unsigned CW = 54;
  localparam int unsigned HW = CW - 32;

  // Commands carried in a word
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // Timer relative offsets
  localparam logic [5:0] TR_CONFIG = 6'h00;
  localparam logic [5:0] TR_LAT_LO = 6'h04;
  localparam logic [5:0] TR_LAT_HI = 6'h08;
  localparam logic [5:0] TR_LATCH  = 6'h0C;
  localparam logic [5:0] TR_ALM_LO = 6'h10;
  localparam logic [5:0] TR_ALM_HI = 6'h14;
  localparam logic [5:0] TR_RLD_LO = 6'h18;
  localparam logic [5:0] TR_RLD_HI = 6'h1C;
  localparam logic [5:0] TR_LOAD   = 6'h20;

  // Group offsets
  localparam logic [7:0] OFF_T_STRIDE = 8'h24;
  localparam logic [7:0] OFF_WDT_BASE = 8'h48;
  localparam logic [7:0] OFF_WDT_END  = 8'h60;
  localparam logic [7:0] OFF_FEED     = 8'h60;
  localparam logic [7:0] OFF_PROTECT  = 8'h64;
  localparam logic [7:0] OFF_INT_ENA  = 8'h70;
  localparam logic [7:0] OFF_INT_RAW  = 8'h74;
  localparam logic [7:0] OFF_INT_ST   = 8'h78;
  localparam logic [7:0] OFF_INT_CLR  = 8'h7C;
  localparam logic [7:0] OFF_DATE     = 8'hF8;
  localparam logic [7:0] OFF_REGCLK   = 8'hFC;

  // Configuration register indexes
  localparam logic [2:0] CFG_TMR_MASK  = 3'd0;
  localparam logic [2:0] CFG_WDT_KEY   = 3'd1;
  localparam logic [2:0] CFG_WDT0_MASK = 3'd2;
  localparam logic [2:0] CFG_WDT1_MASK = 3'd3;
  localparam logic [2:0] CFG_HOLD_MASK = 3'd4;
  localparam logic [2:0] CFG_DATE_MASK = 3'd5;
  localparam logic [2:0] CFG_RCLK_MASK = 3'd6;

  localparam logic [31:0] KEY_RESET = 32'h50D8_3AA1;

  // Timer config bits
  localparam int unsigned C_XTAL   = 9;
  localparam int unsigned C_ALARM  = 10;
  localparam int unsigned C_DIVRST = 12;
  localparam int unsigned C_DIV_LO = 13;
  localparam int unsigned C_AUTO   = 29;
  localparam int unsigned C_UP     = 30;
  localparam int unsigned C_EN     = 31;
  localparam logic [31:0] C_PRE_CLR_MASK = 32'h1FFF_E200;

  // Watchdog word 0 bits
  localparam int unsigned W_FLASHBOOT = 14;
  localparam int unsigned W_EN        = 31;

  // Watchdog stage codes
  localparam logic [2:0] STAGE_STOP = 3'd4;
  localparam logic [1:0] ACT_IRQ    = 2'd1;

  // Reset request codes
  localparam logic [1:0] RST_NONE = 2'd0;

  // Write request into a unit
  typedef struct packed {
    logic        we;
    logic [5:0]  rel;
    logic [31:0] data;
  } tgw_wr_t;

  // Readable state of one timer
  typedef struct packed {
    logic [31:0]   cfg;
    logic [CW-1:0] latched;
    logic [CW-1:0] alarm;
    logic [CW-1:0] reload;
  } tgw_tmr_regs_t;

  // Watchdog event of one word
  typedef struct packed {
    logic       irq;
    logic [1:0] rst;
  } tgw_wdt_evt_t;

endpackage
`default_nettype wire

// File: src/tgw_timer.sv
// One general-purpose timer: prescaler, up/down counter, alarm, reload, latch.
`default_nettype none
module tgw_timer (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   tick_i,
  input  wire logic                   apb_i,
  input  wire logic                   xtal_i,
  input  wire tgw_pkg::tgw_wr_t       wr_i,
  input  wire logic [31:0]            cfg_mask_i,
  output tgw_pkg::tgw_tmr_regs_t      regs_o,
  output logic                        fire_o
);
  import tgw_pkg::*;

  logic [31:0]   cfg_q, cfg_d;
  logic [CW-1:0] cnt_q, cnt_d, lat_q, lat_d, alm_q, alm_d, rld_q, rld_d;
  logic [16:0]   pre_q, pre_d;
  logic [16:0]   div, pre_inc;
  logic [CW-1:0] step;
  logic          edge_sel;

  always_comb begin
    cfg_d  = cfg_q;
    cnt_d  = cnt_q;
    lat_d  = lat_q;
    alm_d  = alm_q;
    rld_d  = rld_q;
    pre_d  = pre_q;
    fire_o = 1'b0;
    div    = {1'b0, cfg_q[C_DIV_LO +: 16]};
    if (div == 17'd0) div = 17'h10000;
    pre_inc  = pre_q + 17'd1;
    edge_sel = cfg_q[C_XTAL] ? xtal_i : apb_i;
    step     = cfg_q[C_UP] ? cnt_q + CW'(1) : cnt_q - CW'(1);
    // prescaled counting on a tick
    if (tick_i && cfg_q[C_EN] && edge_sel) begin
      if (pre_inc >= div) begin
        pre_d = '0;
        cnt_d = step;
        if (cfg_q[C_ALARM] && step == alm_q) begin
          cfg_d[C_ALARM] = 1'b0;
          fire_o = 1'b1;
          if (cfg_q[C_AUTO]) cnt_d = rld_q;
        end
      end else begin
        pre_d = pre_inc;
      end
    end
    // bus writes
    if (wr_i.we) begin
      case (wr_i.rel)
        TR_CONFIG: begin
          cfg_d = wr_i.data & cfg_mask_i;
          if (wr_i.data[C_DIVRST] || (((cfg_q ^ cfg_d) & C_PRE_CLR_MASK) != '0)) pre_d = '0;
        end
        TR_LATCH:  lat_d = cnt_q;
        TR_ALM_LO: alm_d[31:0] = wr_i.data;
        TR_ALM_HI: alm_d[CW-1:32] = wr_i.data[HW-1:0];
        TR_RLD_LO: rld_d[31:0] = wr_i.data;
        TR_RLD_HI: rld_d[CW-1:32] = wr_i.data[HW-1:0];
        TR_LOAD: begin
          cnt_d = rld_q;
          pre_d = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
      cnt_q <= '0;
      lat_q <= '0;
      alm_q <= '0;
      rld_q <= '0;
      pre_q <= '0;
    end else begin
      cfg_q <= cfg_d;
      cnt_q <= cnt_d;
      lat_q <= lat_d;
      alm_q <= alm_d;
      rld_q <= rld_d;
      pre_q <= pre_d;
    end
  end

  assign regs_o = '{cfg: cfg_q, latched: lat_q, alarm: alm_q, reload: rld_q};

endmodule
`default_nettype wire

// File: src/tgw_wdt.sv
// Four-stage watchdog with write protect, feed and prescaler.
`default_nettype none
module tgw_wdt (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              apb_tick_i,
  input  wire tgw_pkg::tgw_wr_t  wr_i,       // rel is the word index 0..5
  input  wire logic              feed_i,
  input  wire logic              prot_we_i,
  input  wire logic [31:0]       key_i,
  input  wire logic [31:0]       mask0_i,
  input  wire logic [31:0]       mask1_i,
  input  wire logic [31:0]       mask_hold_i,
  output logic [31:0]            words_o [6],
  output logic [31:0]            protect_o,
  output tgw_pkg::tgw_wdt_evt_t  evt_o
);
  import tgw_pkg::*;

  logic [31:0] words_q [6];
  logic [31:0] words_d [6];
  logic [31:0] prot_q, prot_d, cnt_q, cnt_d, hold, wm, newv;
  logic [2:0]  stage_q, stage_d, widx, hidx;
  logic [15:0] ps_q, ps_d, pre, ps_inc;
  logic [4:0]  sh;
  logic [1:0]  act;
  logic        running, unlocked;

  always_comb begin
    for (int i = 0; i < 6; i++) words_d[i] = words_q[i];
    prot_d   = prot_q;
    cnt_d    = cnt_q;
    stage_d  = stage_q;
    ps_d     = ps_q;
    evt_o    = '{irq: 1'b0, rst: RST_NONE};
    unlocked = (prot_q == key_i);
    running  = (stage_q < STAGE_STOP) && (words_q[0][W_EN] || words_q[0][W_FLASHBOOT]);
    pre      = words_q[1][31:16];
    if (pre == 16'd0) pre = 16'd1;
    ps_inc   = ps_q + 16'd1;
    hidx     = {1'b0, stage_q[1:0]} + 3'd2;
    hold     = words_q[hidx];
    if (hold == 32'd0) hold = 32'd1;
    sh       = 5'd29 - {2'b00, stage_q[1:0], 1'b0};
    act      = words_q[0][sh +: 2];
    widx     = wr_i.rel[2:0];
    wm       = (widx == 3'd0) ? mask0_i : (widx == 3'd1) ? mask1_i : mask_hold_i;
    newv     = wr_i.data & wm;
    // prescaled stage counting
    if (apb_tick_i && running) begin
      if (ps_inc < pre) begin
        ps_d = ps_inc;
      end else begin
        ps_d = '0;
        if ({1'b0, cnt_q} + 33'd1 < {1'b0, hold}) begin
          cnt_d = cnt_q + 32'd1;
        end else begin
          cnt_d = '0;
          if (act >= 2'd2) begin
            stage_d   = STAGE_STOP;
            evt_o.rst = act - 2'd1;
          end else begin
            evt_o.irq = (act == ACT_IRQ);
            stage_d   = (stage_q < 3'd3) ? stage_q + 3'd1 : STAGE_STOP;
          end
        end
      end
    end
    // protected word writes
    if (wr_i.we && unlocked) begin
      words_d[widx] = newv;
      if (widx == 3'd1 && newv != words_q[1]) ps_d = '0;
      if (widx == 3'd0 && !running && stage_q < STAGE_STOP &&
          (newv[W_EN] || newv[W_FLASHBOOT])) begin
        stage_d = '0;
        cnt_d   = '0;
        ps_d    = '0;
      end
    end
    if (feed_i && unlocked) begin
      stage_d = '0;
      cnt_d   = '0;
      ps_d    = '0;
    end
    if (prot_we_i) prot_d = wr_i.data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) words_q[i] <= '0;
      prot_q  <= KEY_RESET;
      cnt_q   <= '0;
      stage_q <= '0;
      ps_q    <= '0;
    end else begin
      for (int i = 0; i < 6; i++) words_q[i] <= words_d[i];
      prot_q  <= prot_d;
      cnt_q   <= cnt_d;
      stage_q <= stage_d;
      ps_q    <= ps_d;
    end
  end

  assign words_o   = words_q;
  assign protect_o = prot_q;

endmodule
`default_nettype wire

// File: src/timer_group_with_watchdog.sv
// Top level: bus decode, interrupt registers and result register of the timer group.
//
// Usage: each input word on the s_axis side is a register read, a register write
// or a source-clock tick (APB and crystal edges). Every accepted word yields
// exactly one result word on m_axis: read data, hit flag, the interrupt levels
// after the word and the watchdog reset request raised by that word.
// The state updates and the result register loads at the edge that accepts the
// word, and the result is shown the cycle after.
// Throughput is one word per cycle; the single result register lets a new word
// in whenever it is empty or being drained in the same cycle.
// When the receiver stalls, the result is held and s_axis_tready drops until the
// held word is taken; no word is lost.
// Reset clears both timers, the watchdog (protect loads the default key), the
// interrupt registers and the configuration masks to their defaults.
// Configuration writes on cfg_we_i set masks and the unlock key.
`default_nettype none
module timer_group_with_watchdog (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,  // cmd[1:0] offset[9:2] wdata[41:10] apb[42] xtal[43]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,  // rdata[31:0] hit[32] irq_levels[35:33] rst_req[37:36]
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i
);
  import tgw_pkg::*;

  logic [31:0] msk_q [7];
  logic [2:0]  ena_q, ena_d, raw_q, raw_d;
  logic [31:0] date_q, date_d, rclk_q, rclk_d;
  logic        ovalid_q;
  logic [39:0] odata_q;

  logic [1:0]  cmd;
  logic [7:0]  off, trel8, wrel8;
  logic [31:0] wdata, rdata;
  logic        apb, xtal, acc, is_rd, is_wr, tick, mapped, tsel, is_tmr, is_wdt;
  tgw_wr_t     twr0, twr1, wwr;
  tgw_tmr_regs_t tr0, tr1, trs;
  logic        fire0, fire1, feed, prot_we;
  logic [31:0] wwords [6];
  logic [31:0] prot;
  tgw_wdt_evt_t wevt;

  assign cmd   = s_axis_tdata[1:0];
  assign off   = s_axis_tdata[9:2];
  assign wdata = s_axis_tdata[41:10];
  assign apb   = s_axis_tdata[42];
  assign xtal  = s_axis_tdata[43];

  assign s_axis_tready = !ovalid_q || m_axis_tready;
  assign acc   = s_axis_tvalid && s_axis_tready;
  assign tick  = acc && cmd == CMD_TICK;

  // address decode
  assign is_tmr = off < OFF_WDT_BASE;
  assign is_wdt = !is_tmr && off < OFF_WDT_END;
  assign mapped = (off[1:0] == 2'b00) && (off < OFF_WDT_END || off == OFF_FEED ||
                  off == OFF_PROTECT || off == OFF_INT_ENA || off == OFF_INT_RAW ||
                  off == OFF_INT_ST || off == OFF_INT_CLR || off == OFF_DATE ||
                  off == OFF_REGCLK);
  assign is_rd = acc && cmd == CMD_READ && mapped;
  assign is_wr = acc && cmd == CMD_WRITE && mapped;
  assign tsel  = off >= OFF_T_STRIDE;
  assign trel8 = tsel ? off - OFF_T_STRIDE : off;
  assign wrel8 = (off - OFF_WDT_BASE) >> 2;

  assign twr0    = '{we: is_wr && is_tmr && !tsel, rel: trel8[5:0], data: wdata};
  assign twr1    = '{we: is_wr && is_tmr && tsel, rel: trel8[5:0], data: wdata};
  assign wwr     = '{we: is_wr && is_wdt, rel: wrel8[5:0], data: wdata};
  assign feed    = is_wr && off == OFF_FEED;
  assign prot_we = is_wr && off == OFF_PROTECT;

  tgw_timer u_tmr0 (
    .clk_i, .rst_ni, .tick_i(tick), .apb_i(apb), .xtal_i(xtal), .wr_i(twr0),
    .cfg_mask_i(msk_q[CFG_TMR_MASK]), .regs_o(tr0), .fire_o(fire0)
  );

  tgw_timer u_tmr1 (
    .clk_i, .rst_ni, .tick_i(tick), .apb_i(apb), .xtal_i(xtal), .wr_i(twr1),
    .cfg_mask_i(msk_q[CFG_TMR_MASK]), .regs_o(tr1), .fire_o(fire1)
  );

  tgw_wdt u_wdt (
    .clk_i, .rst_ni, .apb_tick_i(tick && apb), .wr_i(wwr), .feed_i(feed),
    .prot_we_i(prot_we), .key_i(msk_q[CFG_WDT_KEY]), .mask0_i(msk_q[CFG_WDT0_MASK]),
    .mask1_i(msk_q[CFG_WDT1_MASK]), .mask_hold_i(msk_q[CFG_HOLD_MASK]),
    .words_o(wwords), .protect_o(prot), .evt_o(wevt)
  );

  // read mux on the state before the word
  assign trs = tsel ? tr1 : tr0;
  always_comb begin
    rdata = '0;
    if (is_rd) begin
      if (is_tmr) begin
        case (trel8[5:0])
          TR_CONFIG: rdata = trs.cfg;
          TR_LAT_LO: rdata = trs.latched[31:0];
          TR_LAT_HI: rdata = 32'(trs.latched[CW-1:32]);
          TR_ALM_LO: rdata = trs.alarm[31:0];
          TR_ALM_HI: rdata = 32'(trs.alarm[CW-1:32]);
          TR_RLD_LO: rdata = trs.reload[31:0];
          TR_RLD_HI: rdata = 32'(trs.reload[CW-1:32]);
          default:   rdata = '0;
        endcase
      end else if (is_wdt) begin
        rdata = wwords[wrel8[2:0]];
      end else begin
        case (off)
          OFF_PROTECT: rdata = prot;
          OFF_INT_ENA: rdata = 32'(ena_q);
          OFF_INT_RAW: rdata = 32'(raw_q);
          OFF_INT_ST:  rdata = 32'(raw_q & ena_q);
          OFF_DATE:    rdata = date_q;
          OFF_REGCLK:  rdata = rclk_q;
          default:     rdata = '0;
        endcase
      end
    end
  end

  // interrupt, date and regclk registers
  always_comb begin
    ena_d  = ena_q;
    raw_d  = raw_q | {wevt.irq, fire1, fire0};
    date_d = date_q;
    rclk_d = rclk_q;
    if (is_wr) begin
      case (off)
        OFF_INT_ENA: ena_d = wdata[2:0];
        OFF_INT_RAW,
        OFF_INT_CLR: raw_d = raw_q & ~wdata[2:0];
        OFF_DATE:    date_d = wdata & msk_q[CFG_DATE_MASK];
        OFF_REGCLK:  rclk_d = wdata & msk_q[CFG_RCLK_MASK];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 7; i++) msk_q[i] <= (i == int'(CFG_WDT_KEY)) ? KEY_RESET : '1;
      ena_q    <= '0;
      raw_q    <= '0;
      date_q   <= '0;
      rclk_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_i <= CFG_RCLK_MASK) msk_q[cfg_idx_i] <= cfg_data_i;
      ena_q  <= ena_d;
      raw_q  <= raw_d;
      date_q <= date_d;
      rclk_q <= rclk_d;
      if (acc) ovalid_q <= 1'b1;
      else if (m_axis_tready) ovalid_q <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (acc) odata_q <= {2'b00, wevt.rst, raw_d & ena_d, (cmd == CMD_READ || cmd == CMD_WRITE)
                         && mapped, rdata};
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;

  // checks
  a_acc_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> m_axis_tvalid) else $error("accepted word gave no result");
  a_rst_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[37:36] != 2'd3) else $error("bad reset code");
  a_rst_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[37:36] != 2'd0) |-> !m_axis_tdata[32])
    else $error("reset request on a bus word");
  a_rd_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[31:0] != 32'd0) |-> m_axis_tdata[32])
    else $error("read data without hit");

endmodule
`default_nettype wire
